>>> design/scaled_cubic_bezier_point_macros.svh
// Assertion macros shared by the scaled cubic Bezier point design.
`ifndef SCALED_CUBIC_BEZIER_POINT_MACROS_SVH
`define SCALED_CUBIC_BEZIER_POINT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define SCB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define SCB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SCB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define SCB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/scb_pkg.sv
// Shared types and constants of the scaled cubic Bezier point pipeline.
`default_nettype none

package scb_pkg;

  localparam int COORD_W    = 24;
  localparam int PARAM_FRAC = 16;
  localparam int T_W        = PARAM_FRAC + 1;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 12;
  // width of scaled handles and of every lerp result
  localparam int EXT_W      = COORD_W + SCALE_W - SCALE_FRAC + 2;
  localparam int NUM_STAGES = 9;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_HANDLE_SCALE = REG_IDX_W'(0);

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);
  localparam logic [T_W-1:0] T_ONE = {1'b1, {PARAM_FRAC{1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] start_pos;
    logic signed [COORD_W-1:0] start_handle;
    logic signed [COORD_W-1:0] end_handle;
    logic signed [COORD_W-1:0] end_pos;
    logic        [T_W-1:0]     param_t;
  } scb_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_coord;
    logic                      saturated;
  } scb_out_t;

endpackage

`default_nettype wire

>>> design/scb_scale.sv
// Two-stage handle scaling: multiply handle offsets by the scale, then add back to points.
`default_nettype none

module scb_scale (
  input  wire logic                                    clk,
  input  wire logic                                    ld_mul,
  input  wire logic                                    ld_add,
  input  wire logic signed [scb_pkg::COORD_W-1:0]      start_pos,
  input  wire logic signed [scb_pkg::COORD_W-1:0]      start_handle,
  input  wire logic signed [scb_pkg::COORD_W-1:0]      end_handle,
  input  wire logic signed [scb_pkg::COORD_W-1:0]      end_pos,
  input  wire logic signed [scb_pkg::SCALE_W-1:0]      handle_scale,
  output logic signed [scb_pkg::EXT_W-1:0]             start_ctl,
  output logic signed [scb_pkg::EXT_W-1:0]             end_ctl,
  output logic signed [scb_pkg::EXT_W-1:0]             start_pt,
  output logic signed [scb_pkg::EXT_W-1:0]             end_pt
);
  import scb_pkg::*;

  localparam int PROD_W = COORD_W + 1 + SCALE_W;
  localparam int SH_W   = PROD_W - SCALE_FRAC;

  logic signed [COORD_W:0]      diff0;
  logic signed [COORD_W:0]      diff1;
  logic signed [PROD_W-1:0]     prod0;
  logic signed [PROD_W-1:0]     prod1;
  logic signed [COORD_W-1:0]    p0_q;
  logic signed [COORD_W-1:0]    p3_q;
  logic signed [SH_W-1:0]       sh0;
  logic signed [SH_W-1:0]       sh1;

  assign diff0 = $signed({start_handle[COORD_W-1], start_handle})
               - $signed({start_pos[COORD_W-1], start_pos});
  assign diff1 = $signed({end_handle[COORD_W-1], end_handle})
               - $signed({end_pos[COORD_W-1], end_pos});

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod0 <= PROD_W'(diff0) * PROD_W'(handle_scale);
      prod1 <= PROD_W'(diff1) * PROD_W'(handle_scale);
      p0_q  <= start_pos;
      p3_q  <= end_pos;
    end
  end

  // arithmetic shift right by the scale fraction
  assign sh0 = $signed(prod0[PROD_W-1:SCALE_FRAC]);
  assign sh1 = $signed(prod1[PROD_W-1:SCALE_FRAC]);

  always_ff @(posedge clk) begin
    if (ld_add) begin
      start_ctl <= EXT_W'(p0_q) + EXT_W'(sh0);
      end_ctl   <= EXT_W'(p3_q) + EXT_W'(sh1);
      start_pt  <= EXT_W'(p0_q);
      end_pt    <= EXT_W'(p3_q);
    end
  end

endmodule

`default_nettype wire

>>> design/scb_lerp.sv
// Two-stage lerp a + floor((b - a) * t / 2^FRAC_W): multiply stage, then add stage.
`default_nettype none

module scb_lerp #(
  parameter int DATA_W = 30,
  parameter int FRAC_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     ld_mul,
  input  wire logic                     ld_add,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  input  wire logic        [FRAC_W:0]   t,
  output logic signed [DATA_W-1:0]      y
);

  localparam int PW = DATA_W + FRAC_W + 3;

  logic signed [DATA_W:0]   diff;
  logic signed [FRAC_W+1:0] t_s;
  logic signed [PW-1:0]     prod;
  logic signed [DATA_W-1:0] a_q;
  logic signed [DATA_W:0]   sh;
  logic signed [DATA_W:0]   sum;

  assign diff = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
  assign t_s  = $signed({1'b0, t});

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod <= PW'(diff) * PW'(t_s);
      a_q  <= a;
    end
  end

  // 0 <= t <= 1, so the scaled step and the sum stay in range of the endpoints
  assign sh  = $signed(prod[DATA_W+FRAC_W:FRAC_W]);
  assign sum = $signed({a_q[DATA_W-1], a_q}) + sh;

  always_ff @(posedge clk) begin
    if (ld_add) begin
      y <= sum[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> design/scb_sat.sv
// Output stage: clamp the wide result to the coordinate range and flag clamping.
`default_nettype none

module scb_sat (
  input  wire logic                           clk,
  input  wire logic                           ld,
  input  wire logic signed [scb_pkg::EXT_W-1:0] r,
  output scb_pkg::scb_out_t                   res
);
  import scb_pkg::*;

  logic [EXT_W-COORD_W:0] top_bits;
  logic                   in_range;

  assign top_bits = r[EXT_W-1:COORD_W-1];
  assign in_range = (&top_bits) || !(|top_bits);

  always_ff @(posedge clk) begin
    if (ld) begin
      res.curve_coord <= in_range ? r[COORD_W-1:0] : (r[EXT_W-1] ? COORD_MIN : COORD_MAX);
      res.saturated   <= !in_range;
    end
  end

endmodule

`default_nettype wire

>>> design/scaled_cubic_bezier_point.sv
// Top level of the scaled cubic Bezier point evaluator, one axis per request.
// Pipeline: 9 register stages from request accept to result valid.
// Throughput: one request per cycle; each stage stalls only when it holds data
// and its successor cannot take it, so bubbles are squeezed out under back-pressure.
// Reset (rst, synchronous): clears all stage valid bits, handle_scale returns to 1.0.
`default_nettype none
`include "scaled_cubic_bezier_point_macros.svh"

module scaled_cubic_bezier_point (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire scb_pkg::scb_in_t                  in_data,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output scb_pkg::scb_out_t                      out_data,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [scb_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [scb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [scb_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import scb_pkg::*;

  // Stage map (index = register stage):
  //   0: handle offsets times scale     1: add back to points -> A, B
  //   2: first-level lerp products      3: s0, s1, s2
  //   4: second-level lerp products     5: i0, i1
  //   6: final lerp product             7: final lerp sum
  //   8: saturation, output register
  localparam int T_STAGES = 6;

  logic signed [SCALE_W-1:0] handle_scale;
  logic                      reg_sel;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_in;
  logic [NUM_STAGES-1:0] ld;

  logic [T_W-1:0] t_clamped;
  logic [T_W-1:0] t_pipe [T_STAGES];

  logic signed [EXT_W-1:0] ctl_a, ctl_b, pt0, pt3;
  logic signed [EXT_W-1:0] s0, s1, s2, i0, i1, r;

  // ---------------------------------------------------------------------------
  // Configuration: one register, handle_scale, at byte address 0
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_HANDLE_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      handle_scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      handle_scale <= $signed(pwdata[SCALE_W-1:0]);
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(handle_scale) : '0;

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    ld[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[0];
  assign vld_in    = {vld[NUM_STAGES-2:0], in_valid};
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (ld[k]) vld[k] <= vld_in[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Parameter t: clamp above 1.0, then carry it alongside the data
  // ---------------------------------------------------------------------------
  assign t_clamped = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;

  always_ff @(posedge clk) begin
    if (ld[0]) t_pipe[0] <= t_clamped;
    for (int k = 1; k < T_STAGES; k++) begin
      if (ld[k]) t_pipe[k] <= t_pipe[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  scb_scale u_scale (
    .clk          (clk),
    .ld_mul       (ld[0]),
    .ld_add       (ld[1]),
    .start_pos    (in_data.start_pos),
    .start_handle (in_data.start_handle),
    .end_handle   (in_data.end_handle),
    .end_pos      (in_data.end_pos),
    .handle_scale (handle_scale),
    .start_ctl    (ctl_a),
    .end_ctl      (ctl_b),
    .start_pt     (pt0),
    .end_pt       (pt3)
  );

  // first level: s0 = lerp(P0, A), s1 = lerp(A, B), s2 = lerp(B, P3)
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_s0 (
    .clk(clk), .ld_mul(ld[2]), .ld_add(ld[3]),
    .a(pt0), .b(ctl_a), .t(t_pipe[1]), .y(s0)
  );
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_s1 (
    .clk(clk), .ld_mul(ld[2]), .ld_add(ld[3]),
    .a(ctl_a), .b(ctl_b), .t(t_pipe[1]), .y(s1)
  );
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_s2 (
    .clk(clk), .ld_mul(ld[2]), .ld_add(ld[3]),
    .a(ctl_b), .b(pt3), .t(t_pipe[1]), .y(s2)
  );

  // second level: i0 = lerp(s0, s1), i1 = lerp(s1, s2)
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_i0 (
    .clk(clk), .ld_mul(ld[4]), .ld_add(ld[5]),
    .a(s0), .b(s1), .t(t_pipe[3]), .y(i0)
  );
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_i1 (
    .clk(clk), .ld_mul(ld[4]), .ld_add(ld[5]),
    .a(s1), .b(s2), .t(t_pipe[3]), .y(i1)
  );

  // final point: lerp(i0, i1)
  scb_lerp #(.DATA_W(EXT_W), .FRAC_W(PARAM_FRAC)) u_lerp_r (
    .clk(clk), .ld_mul(ld[6]), .ld_add(ld[7]),
    .a(i0), .b(i1), .t(t_pipe[5]), .y(r)
  );

  scb_sat u_sat (
    .clk (clk),
    .ld  (ld[NUM_STAGES-1]),
    .r   (r),
    .res (out_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // back-pressure reaches the input only when every stage is full and the sink stalls
  `SCB_ASSERT_NOW(a_full_when_stalled, clk, rst, !in_ready, (&vld) && !out_ready, "input stalled with a free stage")
  // an accepted request always occupies the first stage next cycle
  `SCB_ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && in_ready, vld[0], "accepted request lost")
  // the carried parameter never exceeds 1.0
  `SCB_ASSERT_NOW(a_t_clamped, clk, rst, vld[0], t_pipe[0] <= T_ONE, "parameter not clamped")
  // a clamped result sits exactly at a range limit
  `SCB_ASSERT_NOW(a_sat_limit, clk, rst, out_valid && out_data.saturated, (out_data.curve_coord == COORD_MAX) || (out_data.curve_coord == COORD_MIN), "saturated result off limit")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Testbench for scaled_cubic_bezier_point: drives random and corner requests, predicts each point.
`timescale 1ns / 100ps

module testbench;
  import scb_pkg::*;

  // Nine register stages in the pipe; spare cycles on top when draining.
  localparam int PIPE_DEPTH  = NUM_STAGES;
  localparam int DRAIN_SLACK = PIPE_DEPTH + 8;
  // Worst case is 1620 requests under maximum gaps and the longest stall pattern;
  // this limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_POINTS  = 200;
  localparam logic [T_W-1:0] T_HALF = T_W'(1 << (PARAM_FRAC - 1));

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  scb_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  scb_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  scaled_cubic_bezier_point dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the one configuration register, updated when a write lands.
  logic signed [SCALE_W-1:0] cur_scale = SCALE_RESET;

  // Points predicted for accepted requests, oldest first.
  scb_out_t pending_points[$];

  int errors = 0;
  int cycle_count = 0;

  // Pacing knobs. gap_max = 0 means the sender never idles; stall_mode picks
  // the receiver's back-pressure pattern.
  int gap_max = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // a + floor((b - a) * t / 2^PARAM_FRAC). All operands stay well inside 64 bits
  // (differences up to ~2^29, t up to 2^16), so a plain arithmetic shift is exact.
  function automatic longint blend_toward(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> PARAM_FRAC);
  endfunction

  // Pull the handle toward (or mirror it through) its point by the Q4.12 scale.
  function automatic longint stretch_handle(longint p, longint h, longint sc);
    return p + (((h - p) * sc) >>> SCALE_FRAC);
  endfunction

  function automatic scb_out_t predict_curve_point(scb_in_t req, logic signed [SCALE_W-1:0] scale);
    longint   sc, p0, h0, h1, p3, t;
    longint   a, b, s0, s1, s2, i0, i1, r;
    longint   hi_lim, lo_lim;
    scb_out_t res;
    sc = scale;
    p0 = req.start_pos;
    h0 = req.start_handle;
    h1 = req.end_handle;
    p3 = req.end_pos;
    // t above one is pinned to exactly one, silently
    if (req.param_t > T_ONE) t = T_ONE;
    else t = req.param_t;
    a  = stretch_handle(p0, h0, sc);
    b  = stretch_handle(p3, h1, sc);
    s0 = blend_toward(p0, a, t);
    s1 = blend_toward(a, b, t);
    s2 = blend_toward(b, p3, t);
    i0 = blend_toward(s0, s1, t);
    i1 = blend_toward(s1, s2, t);
    r  = blend_toward(i0, i1, t);
    hi_lim = COORD_MAX;
    lo_lim = COORD_MIN;
    res.saturated = 1'b0;
    if (r > hi_lim) begin
      r = hi_lim;
      res.saturated = 1'b1;
    end else if (r < lo_lim) begin
      r = lo_lim;
      res.saturated = 1'b1;
    end
    res.curve_coord = COORD_W'(r);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic scb_in_t make_request(longint p0, longint h0, longint h1, longint p3,
                                           logic [T_W-1:0] t);
    scb_in_t req;
    req.start_pos    = COORD_W'(p0);
    req.start_handle = COORD_W'(h0);
    req.end_handle   = COORD_W'(h1);
    req.end_pos      = COORD_W'(p3);
    req.param_t      = t;
    return req;
  endfunction

  // Called on a rising edge; returns on the edge where the request was taken, or after
  // the idle gap that follows it. Valid stays up between back-to-back requests within a burst.
  task automatic send_request(input scb_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_points.push_back(predict_curve_point(req, cur_scale));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Block goes idle: nothing in flight, then a margin of spare cycles.
  task automatic wait_all_points();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Two-phase write; the register takes the value on the access-phase edge
  // (pready is tied high).
  task automatic write_handle_scale(input logic signed [SCALE_W-1:0] scale);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_HANDLE_SCALE, 2'b00});
    pwdata  <= APB_DATA_W'(scale);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cur_scale = scale;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver back-pressure: always ready, random, short periodic, long stalls.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((stall_tick % 7) >= 2);
      default: out_ready <= ((stall_tick % 32) < 8);
    endcase
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    scb_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result: curve_coord %0d saturated %0b",
               out_data.curve_coord, out_data.saturated);
        errors++;
      end else begin
        want = pending_points.pop_front();
        if (out_data.curve_coord !== want.curve_coord) begin
          $error("curve_coord mismatch: expected %0d, actual %0d",
                 want.curve_coord, out_data.curve_coord);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0b, actual %0b",
                 want.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  // Hard stop if the handshakes ever hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scaled_cubic_bezier_point verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint random_coord();
    case ($urandom_range(0, 5))
      0, 1: return longint'(COORD_W'($urandom));
      2: return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
      3: return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      4: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return longint'(COORD_W'($urandom)) >>> $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [T_W-1:0] random_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return T_ONE;
      2: return T_W'($urandom);   // full field, above one half the time
      default: return T_W'($urandom_range(0, 1 << PARAM_FRAC));
    endcase
  endfunction

  // Mostly realistic segments (controls clustered around one spot), the rest
  // fully independent coordinates.
  function automatic scb_in_t random_request();
    longint base, p0, h0, h1, p3;
    int     spread;
    if ($urandom_range(0, 2) != 0) begin
      base   = random_coord();
      spread = 1 << $urandom_range(4, 20);
      p0 = base + $urandom_range(0, 2 * spread) - spread;
      h0 = base + $urandom_range(0, 2 * spread) - spread;
      h1 = base + $urandom_range(0, 2 * spread) - spread;
      p3 = base + $urandom_range(0, 2 * spread) - spread;
    end else begin
      p0 = random_coord();
      h0 = random_coord();
      h1 = random_coord();
      p3 = random_coord();
    end
    return make_request(p0, h0, h1, p3, random_param());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset scale of 1.0: plain curve, field extremes, t at 0, 1 and above 1.
  task automatic test_reset_scale();
    gap_max    = 3;
    stall_mode = 1;
    send_request(make_request(0, 0, 0, 0, '0));
    send_request(make_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, T_ONE));
    send_request(make_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, T_HALF));
    send_request(make_request(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_HALF));
    send_request(make_request(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, T_W'(16'h4000)));
    // alternating bit patterns, t at its largest encoding
    send_request(make_request(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, '1));
    // just past one
    send_request(make_request(100, 200, -300, 400, T_ONE + 1'b1));
    send_request(make_request(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, T_W'(17'h0FFFF)));
    send_request(make_request(-1, 1, -1, 1, T_W'(1)));
    wait_all_points();
  endtask

  // Scale extremes: overflow both ways, mirrored handles, collapsed handles.
  task automatic test_scale_extremes();
    gap_max    = 2;
    stall_mode = 2;
    write_handle_scale(16'sh7FFF);
    send_request(make_request(0, COORD_MAX, COORD_MAX, 0, T_HALF));  // clamps high
    send_request(make_request(0, COORD_MIN, COORD_MIN, 0, T_HALF));  // clamps low
    send_request(make_request(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_ONE));
    send_request(make_request(1000, -2000, 3000, -4000, T_W'(16'h3000)));
    wait_all_points();
    // most negative scale mirrors handles ~8x through their points
    write_handle_scale(16'sh8000);
    send_request(make_request(0, COORD_MAX, COORD_MAX, 0, T_HALF));
    send_request(make_request(0, COORD_MIN, COORD_MIN, 0, T_HALF));
    send_request(make_request(12345, -23456, 34567, -45678, T_HALF));
    wait_all_points();
    // zero scale: handles sit on their points
    write_handle_scale(16'sh0000);
    send_request(make_request(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, T_HALF));
    send_request(make_request(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, T_W'(16'h1234)));
    wait_all_points();
    write_handle_scale(-16'sd4096);
    send_request(make_request(100, 5000, -7000, 200, T_W'(16'h6000)));
    send_request(make_request(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, T_HALF));
    wait_all_points();
  endtask

  // Random segments over several scale settings and pacing mixes.
  task automatic test_random_segments();
    logic signed [SCALE_W-1:0] scale;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: scale = SCALE_RESET;
        1: scale = SCALE_W'($urandom);
        2: scale = SCALE_W'($urandom_range(0, 8192));
        3: scale = -SCALE_W'($urandom_range(1, 8192));
        4: scale = 16'sh7FFF;
        5: scale = SCALE_W'($urandom);
        6: scale = 16'sh8000;
        default: scale = SCALE_W'($urandom_range(3584, 4608));
      endcase
      write_handle_scale(scale);
      // first phase runs flat out on both sides
      gap_max    = (phase == 0) ? 0 : $urandom_range(1, 12);
      stall_mode = phase % 4;
      burst_left = 0;
      repeat (PHASE_POINTS) send_request(random_request());
      wait_all_points();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_scale();
    test_scale_extremes();
    test_random_segments();
    if (errors == 0) begin
      $display("scaled_cubic_bezier_point verification clean");
    end else begin
      $display("scaled_cubic_bezier_point verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/scb_pkg.sv
design/scb_scale.sv
design/scb_lerp.sv
design/scb_sat.sv
design/scaled_cubic_bezier_point.sv
tb/testbench.sv
